### hdl/rtsv_pkg.sv
// ----------------------------------------------------------------------------
// rtsv_pkg
// shared widths, limits and the arctangent table of the right triangle solver
// ----------------------------------------------------------------------------
package rtsv_pkg;

   // default sizes handed to the top level
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int LEG_WIDTH_DEF     = 16;

   // arctangent table length, upper bound on the cordic chain
   localparam int TABLE_LEN      = 24;
   // legs enter the cordic scaled by 2^24
   localparam int LEG_SCALE_BITS = 24;

   // result field widths
   localparam int HYP_W = 16;
   localparam int RAD_W = 16;
   localparam int DEG_W = 15;

   // angle accumulator, units of 2^-30 rad
   localparam int Z_W = 32;

   typedef logic signed [Z_W-1:0]   angle_type;
   typedef logic signed [RAD_W-1:0] rad_type;
   typedef logic signed [DEG_W-1:0] deg_type;

   // pi / 2 in units of 2^-30 rad
   localparam angle_type HALF_PI_Q30 = 32'sd1686629713;
   // 180 / pi scaled by 2^24
   localparam logic signed [31:0] DEG_PER_RAD_Q24 = 32'sd961263669;

   localparam rad_type RAD_LIMIT = 16'sd25736;
   localparam deg_type DEG_LIMIT = 15'sd11520;
   localparam logic [HYP_W-1:0] HYP_MAX = 16'hFFFF;

   // atan(2^-i) in units of 2^-30 rad
   localparam angle_type ATAN_Q30 [TABLE_LEN] = '{
      32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
      32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
      32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
      32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
      32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
      32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F
   };

endpackage

### hdl/rtsv_cordic_cell.sv
// ----------------------------------------------------------------------------
// rtsv_cordic_cell
// one vectoring micro-rotation, registered, drives y towards zero
// ----------------------------------------------------------------------------
module rtsv_cordic_cell #(
   parameter int XY_W  = 42,
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic signed [XY_W-1:0]  x_i,
   input  logic signed [XY_W-1:0]  y_i,
   input  rtsv_pkg::angle_type     z_i,
   output logic signed [XY_W-1:0]  x_o,
   output logic signed [XY_W-1:0]  y_o,
   output rtsv_pkg::angle_type     z_o
);
   import rtsv_pkg::*;

   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   logic signed [XY_W-1:0] x_ff, x_in;
   logic signed [XY_W-1:0] y_ff, y_in;
   angle_type              z_ff, z_in;

   // arithmetic shift is a floor shift
   assign dx = y_i >>> STAGE;
   assign dy = x_i >>> STAGE;

   always_comb begin
      if (y_i > 0) begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ATAN_Q30[STAGE];
      end else begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ATAN_Q30[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

### hdl/rtsv_root_cell.sv
// ----------------------------------------------------------------------------
// rtsv_root_cell
// one digit of the restoring square root, registered
// ----------------------------------------------------------------------------
module rtsv_root_cell #(
   parameter int LEG_W = 16,
   parameter int STEP  = 0
) (
   input  logic                 clock,
   input  logic [2*LEG_W-1:0]   rem_i,
   input  logic [2*LEG_W-1:0]   root_i,
   output logic [2*LEG_W-1:0]   rem_o,
   output logic [2*LEG_W-1:0]   root_o
);
   localparam int N_W   = 2 * LEG_W;
   localparam int SHIFT = 2 * (LEG_W - 1 - STEP);
   localparam logic [N_W-1:0] BIT = {{(N_W-1){1'b0}}, 1'b1} << SHIFT;

   logic [N_W:0]   trial;
   logic [N_W-1:0] rem_ff, rem_in;
   logic [N_W-1:0] root_ff, root_in;

   assign trial = {1'b0, root_i} + {1'b0, BIT};

   always_comb begin
      if ({1'b0, rem_i} >= trial) begin
         rem_in  = rem_i - trial[N_W-1:0];
         root_in = (root_i >> 1) + BIT;
      end else begin
         rem_in  = rem_i;
         root_in = root_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

### hdl/rtsv_angle_out.sv
// ----------------------------------------------------------------------------
// rtsv_angle_out
// clamps a cordic angle and scales it to radians q2.14 and degrees q8.7
// ----------------------------------------------------------------------------
module rtsv_angle_out (
   input  logic                 clock,
   input  rtsv_pkg::angle_type  z_i,
   output rtsv_pkg::rad_type    rad_o,
   output rtsv_pkg::deg_type    deg_o
);
   import rtsv_pkg::*;

   localparam int PROD_W = 64;
   localparam int SUM_W  = Z_W + 1;

   // stage a: clamp and radians
   angle_type               zc_ff, zc_in;
   rad_type                 rad_a_ff, rad_a_in;
   logic signed [SUM_W-1:0] rad_sum;
   logic signed [SUM_W-1:0] rad_sh;
   // stage b: degree product
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   rad_type                  rad_b_ff;
   // stage c: degree rounding
   logic signed [PROD_W-1:0] deg_sum;
   logic signed [PROD_W-1:0] deg_sh;
   deg_type                  deg_ff, deg_in;
   rad_type                  rad_c_ff;

   always_comb begin
      if (z_i > HALF_PI_Q30) begin
         zc_in = HALF_PI_Q30;
      end else if (z_i < -HALF_PI_Q30) begin
         zc_in = -HALF_PI_Q30;
      end else begin
         zc_in = z_i;
      end
      rad_sum = SUM_W'(zc_in) + SUM_W'(32'sd32768);
      rad_sh  = rad_sum >>> 16;
      if (rad_sh > SUM_W'(RAD_LIMIT)) begin
         rad_a_in = RAD_LIMIT;
      end else if (rad_sh < -SUM_W'(RAD_LIMIT)) begin
         rad_a_in = -RAD_LIMIT;
      end else begin
         rad_a_in = rad_sh[RAD_W-1:0];
      end
   end

   assign prod_in = PROD_W'(zc_ff) * PROD_W'(DEG_PER_RAD_Q24);

   always_comb begin
      deg_sum = prod_ff + (PROD_W'(64'sd1) <<< 46);
      deg_sh  = deg_sum >>> 47;
      if (deg_sh > PROD_W'(DEG_LIMIT)) begin
         deg_in = DEG_LIMIT;
      end else if (deg_sh < -PROD_W'(DEG_LIMIT)) begin
         deg_in = -DEG_LIMIT;
      end else begin
         deg_in = deg_sh[DEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      zc_ff    <= zc_in;
      rad_a_ff <= rad_a_in;
      prod_ff  <= prod_in;
      rad_b_ff <= rad_a_ff;
      deg_ff   <= deg_in;
      rad_c_ff <= rad_b_ff;
   end

   assign rad_o = rad_c_ff;
   assign deg_o = deg_ff;

endmodule

### hdl/rtsv_delay.sv
// ----------------------------------------------------------------------------
// rtsv_delay
// fixed-length shift register that lines up the two halves of the pipeline
// ----------------------------------------------------------------------------
module rtsv_delay #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1
) (
   input  logic              clock,
   input  logic [WIDTH-1:0]  din,
   output logic [WIDTH-1:0]  dout
);
   logic [WIDTH-1:0] stage_ff [DEPTH];

   always_ff @(posedge clock) begin
      stage_ff[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
         stage_ff[i] <= stage_ff[i-1];
      end
   end

   assign dout = stage_ff[DEPTH-1];

endmodule

### hdl/right_triangle_solver.sv
// ----------------------------------------------------------------------------
// right_triangle_solver
// hypotenuse and both acute angles of a right triangle from its signed legs
// ----------------------------------------------------------------------------
// usage
//   a beat on the request side is taken at a rising edge with start high and
//   busy low; busy is held low, so a new pair of legs may enter every cycle
//   each result beat sits on the rsp_ ports for one cycle, marked by
//   rsp_strobe, and is taken at the edge that ends that cycle
//   the pipeline depth from start to strobe is set by the longer of the square
//   root chain (one cell per root bit) and the cordic chain (one cell per
//   micro-rotation); throughput one beat per cycle
//   results leave in the order the legs came in, one per beat
//   reset clears the strobe pipeline only, so beats in flight are dropped;
//   data registers carry no reset
//   the receiver cannot stall, so there is no back pressure anywhere
//   both legs zero gives hypotenuse zero, zero angles and rsp_degenerate high
// ----------------------------------------------------------------------------
module right_triangle_solver #(
   parameter int CORDIC_STAGES = rtsv_pkg::CORDIC_STAGES_DEF,
   parameter int LEG_WIDTH     = rtsv_pkg::LEG_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request beat
   input  logic                           start,
   output logic                           busy,
   input  logic signed [LEG_WIDTH-1:0]    req_leg_a,
   input  logic signed [LEG_WIDTH-1:0]    req_leg_b,
   // result beat
   output logic                           rsp_strobe,
   output logic [rtsv_pkg::HYP_W-1:0]     rsp_hypotenuse,
   output rtsv_pkg::rad_type              rsp_angle_a_rad,
   output rtsv_pkg::rad_type              rsp_angle_b_rad,
   output rtsv_pkg::deg_type              rsp_angle_a_deg,
   output rtsv_pkg::deg_type              rsp_angle_b_deg,
   output logic                           rsp_degenerate
);
   import rtsv_pkg::*;

   // square root operand width and cordic datapath width (two guard bits
   // cover the cordic gain on a diagonal vector)
   localparam int N_W  = 2 * LEG_WIDTH;
   localparam int XY_W = LEG_WIDTH + LEG_SCALE_BITS + 2;

   // both chains end in a delay line so that they meet at the output register
   localparam int SPAN       = (LEG_WIDTH > CORDIC_STAGES) ? LEG_WIDTH : CORDIC_STAGES;
   localparam int HYP_DELAY  = SPAN - LEG_WIDTH + 1;
   localparam int ANG_DELAY  = SPAN - CORDIC_STAGES + 1;
   localparam int PIPE_DEPTH = SPAN + 6;
   localparam int ANG_W      = 2 * RAD_W + 2 * DEG_W;
   localparam int EXT_W      = (LEG_WIDTH > HYP_W) ? LEG_WIDTH + 1 : HYP_W + 1;

   // ---------------------------------------------------------------- input
   logic signed [LEG_WIDTH-1:0] leg_a_ff, leg_b_ff;
   logic [LEG_WIDTH-1:0]        mag_a_ff, mag_a_in;
   logic [LEG_WIDTH-1:0]        mag_b_ff, mag_b_in;

   // ------------------------------------------------------------ hypotenuse
   logic [N_W-1:0]      sq_a_ff, sq_a_in;
   logic [N_W-1:0]      sq_b_ff, sq_b_in;
   logic [N_W-1:0]      sum_ff, sum_in;
   logic [N_W-1:0]      rem_w  [LEG_WIDTH+1];
   logic [N_W-1:0]      root_w [LEG_WIDTH+1];
   logic [LEG_WIDTH:0]  rounded;
   logic [EXT_W-1:0]    rounded_ext;
   logic [HYP_W-1:0]    hyp_ff, hyp_in;
   logic [HYP_W-1:0]    hyp_d;

   // ---------------------------------------------------------------- angles
   logic signed [XY_W-1:0] xa_w [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] ya_w [CORDIC_STAGES+1];
   angle_type              za_w [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] xb_w [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] yb_w [CORDIC_STAGES+1];
   angle_type              zb_w [CORDIC_STAGES+1];
   rad_type                rad_a, rad_b;
   deg_type                deg_a, deg_b;
   logic [ANG_W-1:0]       ang_d;

   // ---------------------------------------------------------------- output
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic [HYP_W-1:0]      out_hyp_ff;
   rad_type               out_rad_a_ff, out_rad_a_in;
   rad_type               out_rad_b_ff, out_rad_b_in;
   deg_type               out_deg_a_ff, out_deg_a_in;
   deg_type               out_deg_b_ff, out_deg_b_in;
   logic                  out_degen_ff, out_degen_in;

   // every cycle can take a beat
   assign busy = 1'b0;

   // strobe pipeline, one bit per register stage
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // magnitudes; the most negative leg wraps to its correct unsigned value
   always_comb begin
      mag_a_in = req_leg_a[LEG_WIDTH-1] ? (~req_leg_a + LEG_WIDTH'(1)) : req_leg_a;
      mag_b_in = req_leg_b[LEG_WIDTH-1] ? (~req_leg_b + LEG_WIDTH'(1)) : req_leg_b;
   end

   // squares, then their sum; a*a + b*b never needs more than 2*LEG_WIDTH bits
   assign sq_a_in = N_W'(mag_a_ff) * N_W'(mag_a_ff);
   assign sq_b_in = N_W'(mag_b_ff) * N_W'(mag_b_ff);
   assign sum_in  = sq_a_ff + sq_b_ff;

   always_ff @(posedge clock) begin
      leg_a_ff <= req_leg_a;
      leg_b_ff <= req_leg_b;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      sq_a_ff  <= sq_a_in;
      sq_b_ff  <= sq_b_in;
      sum_ff   <= sum_in;
      hyp_ff   <= hyp_in;
   end

   // square root chain, one result bit per cell, most significant first
   assign rem_w[0]  = sum_ff;
   assign root_w[0] = '0;

   for (genvar k = 0; k < LEG_WIDTH; k++) begin : g_root
      rtsv_root_cell #(
         .LEG_W (LEG_WIDTH),
         .STEP  (k)
      ) u_cell (
         .clock  (clock),
         .rem_i  (rem_w[k]),
         .root_i (root_w[k]),
         .rem_o  (rem_w[k+1]),
         .root_o (root_w[k+1])
      );
   end

   // round to nearest: the remainder above the root means past the half
   always_comb begin
      rounded     = {1'b0, root_w[LEG_WIDTH][LEG_WIDTH-1:0]}
                  + (LEG_WIDTH+1)'(rem_w[LEG_WIDTH] > root_w[LEG_WIDTH]);
      rounded_ext = EXT_W'(rounded);
      if (rounded_ext > EXT_W'(HYP_MAX)) begin
         hyp_in = HYP_MAX;
      end else begin
         hyp_in = rounded_ext[HYP_W-1:0];
      end
   end

   rtsv_delay #(
      .WIDTH (HYP_W),
      .DEPTH (HYP_DELAY)
   ) u_hyp_delay (
      .clock (clock),
      .din   (hyp_ff),
      .dout  (hyp_d)
   );

   // cordic chains: angle a is atan2(a, |b|), angle b is atan2(b, |a|)
   assign xa_w[0] = {2'b00, mag_b_ff, {LEG_SCALE_BITS{1'b0}}};
   assign ya_w[0] = {{2{leg_a_ff[LEG_WIDTH-1]}}, leg_a_ff, {LEG_SCALE_BITS{1'b0}}};
   assign za_w[0] = '0;
   assign xb_w[0] = {2'b00, mag_a_ff, {LEG_SCALE_BITS{1'b0}}};
   assign yb_w[0] = {{2{leg_b_ff[LEG_WIDTH-1]}}, leg_b_ff, {LEG_SCALE_BITS{1'b0}}};
   assign zb_w[0] = '0;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      rtsv_cordic_cell #(
         .XY_W  (XY_W),
         .STAGE (i)
      ) u_cell_a (
         .clock (clock),
         .x_i   (xa_w[i]),
         .y_i   (ya_w[i]),
         .z_i   (za_w[i]),
         .x_o   (xa_w[i+1]),
         .y_o   (ya_w[i+1]),
         .z_o   (za_w[i+1])
      );

      rtsv_cordic_cell #(
         .XY_W  (XY_W),
         .STAGE (i)
      ) u_cell_b (
         .clock (clock),
         .x_i   (xb_w[i]),
         .y_i   (yb_w[i]),
         .z_i   (zb_w[i]),
         .x_o   (xb_w[i+1]),
         .y_o   (yb_w[i+1]),
         .z_o   (zb_w[i+1])
      );
   end

   // clamp to a quarter turn and scale, three stages each
   rtsv_angle_out u_out_a (
      .clock (clock),
      .z_i   (za_w[CORDIC_STAGES]),
      .rad_o (rad_a),
      .deg_o (deg_a)
   );

   rtsv_angle_out u_out_b (
      .clock (clock),
      .z_i   (zb_w[CORDIC_STAGES]),
      .rad_o (rad_b),
      .deg_o (deg_b)
   );

   rtsv_delay #(
      .WIDTH (ANG_W),
      .DEPTH (ANG_DELAY)
   ) u_ang_delay (
      .clock (clock),
      .din   ({rad_a, rad_b, deg_a, deg_b}),
      .dout  (ang_d)
   );

   // a zero hypotenuse occurs only with both legs zero; angles forced to zero
   always_comb begin
      out_degen_in = (hyp_d == '0);
      if (out_degen_in) begin
         out_rad_a_in = '0;
         out_rad_b_in = '0;
         out_deg_a_in = '0;
         out_deg_b_in = '0;
      end else begin
         out_rad_a_in = ang_d[ANG_W-1 -: RAD_W];
         out_rad_b_in = ang_d[ANG_W-RAD_W-1 -: RAD_W];
         out_deg_a_in = ang_d[2*DEG_W-1 -: DEG_W];
         out_deg_b_in = ang_d[DEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      out_hyp_ff   <= hyp_d;
      out_rad_a_ff <= out_rad_a_in;
      out_rad_b_ff <= out_rad_b_in;
      out_deg_a_ff <= out_deg_a_in;
      out_deg_b_ff <= out_deg_b_in;
      out_degen_ff <= out_degen_in;
   end

   assign rsp_strobe      = valid_ff[PIPE_DEPTH-1];
   assign rsp_hypotenuse  = out_hyp_ff;
   assign rsp_angle_a_rad = out_rad_a_ff;
   assign rsp_angle_b_rad = out_rad_b_ff;
   assign rsp_angle_a_deg = out_deg_a_ff;
   assign rsp_angle_b_deg = out_deg_b_ff;
   assign rsp_degenerate  = out_degen_ff;

   // ------------------------------------------------------------ assertions
   // every accepted beat comes out after the full pipeline depth
   a_latency : assert property (@(posedge clock) disable iff (reset)
      start |-> ##PIPE_DEPTH rsp_strobe)
      else $error("result beat missing after accepted request");

   // no result beat without a request that long ago
   a_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, PIPE_DEPTH))
      else $error("result beat without matching request");

   // radian outputs stay within a quarter turn
   a_rad_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_angle_a_rad <= RAD_LIMIT) && (rsp_angle_a_rad >= -RAD_LIMIT)
                  && (rsp_angle_b_rad <= RAD_LIMIT) && (rsp_angle_b_rad >= -RAD_LIMIT))
      else $error("radian angle out of range");

   // degree outputs stay within ninety degrees
   a_deg_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_angle_a_deg <= DEG_LIMIT) && (rsp_angle_a_deg >= -DEG_LIMIT)
                  && (rsp_angle_b_deg <= DEG_LIMIT) && (rsp_angle_b_deg >= -DEG_LIMIT))
      else $error("degree angle out of range");

endmodule
